>>> rtl/rmap_pkg.sv
// ----------------------------------------------------------------------------
// Resource map allocator package
// Shared constants and types for the free-segment cell chain.
// ----------------------------------------------------------------------------
package rmap_pkg;

  localparam int MaxSegDefault = 16;

  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_GET   = 3'd3;
  localparam logic [2:0] MODE_AVAIL = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Per-cycle command broadcast to every cell
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;  // overwrite cell sel with base/len
  localparam logic [2:0] OP_REMOVE = 3'd2;  // cells >= sel take right neighbor
  localparam logic [2:0] OP_INSERT = 3'd3;  // cells > sel take left, sel takes base/len
  localparam logic [2:0] OP_CLEAR  = 3'd4;  // drop every segment

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] base;
    logic [31:0] len;
  } rmap_cmd_t;

  // Per-cell compare flags returned to the controller
  typedef struct packed {
    logic valid;
    logic le_addr;   // base <= addr
    logic fits;      // len >= size
    logic covers;    // base <= addr < end
  } rmap_flag_t;

endpackage

>>> rtl/rmap_cell.sv
// ----------------------------------------------------------------------------
// Resource map cell
// Holds one free segment and shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module rmap_cell
  import rmap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rmap_cmd_t   cmd,
  input  logic        is_sel,
  input  logic        above_sel,
  input  logic        left_valid,
  input  logic [31:0] left_base,
  input  logic [31:0] left_len,
  input  logic        right_valid,
  input  logic [31:0] right_base,
  input  logic [31:0] right_len,
  input  logic [31:0] addr,
  input  logic [31:0] size,
  output logic        valid,
  output logic [31:0] base,
  output logic [31:0] len,
  output rmap_flag_t  flag
);

  logic [32:0] seg_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_WRITE: if (is_sel) begin
          valid <= 1'b1;
          base  <= cmd.base;
          len   <= cmd.len;
        end
        OP_REMOVE: if (is_sel || above_sel) begin
          valid <= right_valid;
          base  <= right_base;
          len   <= right_len;
        end
        OP_INSERT: begin
          if (is_sel) begin
            valid <= 1'b1;
            base  <= cmd.base;
            len   <= cmd.len;
          end else if (above_sel) begin
            valid <= left_valid;
            base  <= left_base;
            len   <= left_len;
          end
        end
        OP_CLEAR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign seg_end      = {1'b0, base} + {1'b0, len};
  assign flag.valid   = valid;
  assign flag.le_addr = valid && (base <= addr);
  assign flag.fits    = valid && (len >= size);
  assign flag.covers  = valid && (base <= addr) && (seg_end > {1'b0, addr});

endmodule

>>> rtl/rmap_chain.sv
// ----------------------------------------------------------------------------
// Resource map chain
// Row of segment cells; each cell sees its two neighbors.
// ----------------------------------------------------------------------------
module rmap_chain
  import rmap_pkg::*;
#(
  parameter int MaxSeg = MaxSegDefault,
  parameter int IdxW = (MaxSeg > 1) ? $clog2(MaxSeg) : 1
)(
  input  logic                    clk,
  input  logic                    rst,
  input  rmap_cmd_t               cmd,
  input  logic [IdxW-1:0]         sel,
  input  logic [31:0]             addr,
  input  logic [31:0]             size,
  output logic [MaxSeg-1:0][31:0] bases,
  output logic [MaxSeg-1:0][31:0] lens,
  output rmap_flag_t [MaxSeg-1:0] flags
);

  logic [MaxSeg-1:0] valids;

  for (genvar g = 0; g < MaxSeg; g++) begin : g_cell
    logic        lv, rv;
    logic [31:0] lb, ll, rb, rl;
    if (g == 0) begin : g_l0
      assign lv = 1'b0; assign lb = '0; assign ll = '0;
    end else begin : g_l
      assign lv = valids[g-1]; assign lb = bases[g-1]; assign ll = lens[g-1];
    end
    if (g == MaxSeg - 1) begin : g_rn
      assign rv = 1'b0; assign rb = '0; assign rl = '0;
    end else begin : g_r
      assign rv = valids[g+1]; assign rb = bases[g+1]; assign rl = lens[g+1];
    end
    rmap_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .is_sel(sel == IdxW'(g)), .above_sel(IdxW'(g) > sel),
      .left_valid(lv), .left_base(lb), .left_len(ll),
      .right_valid(rv), .right_base(rb), .right_len(rl),
      .addr(addr), .size(size),
      .valid(valids[g]), .base(bases[g]), .len(lens[g]), .flag(flags[g])
    );
  end

endmodule

>>> rtl/resource_map_allocator_unit.sv
// Sequence: an accepted item is evaluated in S_EVAL and its result is held in S_OUT for
// alloc, plain free, plain get and bad requests; init that reloads cell 0, a free that joins
// both neighbors and a get cut from the middle also pass S_FIX, and a free that discards a segment repeats S_EVAL.
// Avail scans one cell per cycle in S_SCAN before S_OUT. Items: one item in flight; the next
// item is accepted the cycle after the result is taken.
// Reset empties the segment list and returns the handshake to idle.
// ----------------------------------------------------------------------------
// Resource map allocator unit
// First-fit allocator over an address-sorted chain of free-segment cells.
// ----------------------------------------------------------------------------
module resource_map_allocator_unit
  import rmap_pkg::*;
#(
  parameter int MaxSeg = MaxSegDefault
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] req_size,
  input  logic [31:0] req_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] result_addr,
  output logic [31:0] avail_len,
  output logic        lost_valid,
  output logic [31:0] lost_base,
  output logic [31:0] lost_len
);

  localparam int IdxW = (MaxSeg > 1) ? $clog2(MaxSeg) : 1;
  localparam int CntW = $clog2(MaxSeg + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state, state_next;
  logic [2:0]  r_mode;
  logic [31:0] r_size, r_addr;

  rmap_cmd_t                cmd;
  logic [IdxW-1:0]          sel;
  logic [MaxSeg-1:0][31:0]  bases, lens;
  rmap_flag_t [MaxSeg-1:0]  flags;
  logic [CntW-1:0]          cnt;
  logic [IdxW-1:0]          scan;
  rmap_cmd_t                fix_cmd;
  logic [IdxW-1:0]          fix_sel;

  rmap_chain #(.MaxSeg(MaxSeg), .IdxW(IdxW)) u_chain (
    .clk(clk), .rst(rst), .cmd(cmd), .sel(sel), .addr(r_addr), .size(r_size),
    .bases(bases), .lens(lens), .flags(flags)
  );

  // Priority pickers over the flag row
  logic [CntW-1:0] n_le;      // cells with base <= addr (sorted: a prefix)
  logic            fit_hit, cov_hit;
  logic [IdxW-1:0] fit_idx, cov_idx;

  always_comb begin
    n_le = '0;
    fit_hit = 1'b0; fit_idx = '0;
    cov_hit = 1'b0; cov_idx = '0;
    cnt = '0;
    for (int k = 0; k < MaxSeg; k++) begin
      if (flags[k].valid) cnt = CntW'(k + 1);
      if (flags[k].le_addr) n_le = CntW'(k + 1);
    end
    for (int k = MaxSeg - 1; k >= 0; k--) begin
      if (flags[k].fits) begin fit_hit = 1'b1; fit_idx = IdxW'(k); end
      if (flags[k].covers) begin cov_hit = 1'b1; cov_idx = IdxW'(k); end
    end
  end

  // Neighbor values for free and the selected segment for get
  logic [IdxW-1:0] li, ri;
  logic            has_l_seg, has_r_seg;
  logic [32:0]     l_end, rend, c_end;
  logic [31:0]     lb, ll, rb, rl, cb, cl;
  logic            full;

  always_comb begin
    li = IdxW'(n_le - CntW'(1));
    ri = IdxW'(n_le);
    has_l_seg = (n_le != '0);
    has_r_seg = (n_le < cnt);
    lb = bases[li]; ll = lens[li];
    rb = bases[ri]; rl = lens[ri];
    cb = bases[cov_idx]; cl = lens[cov_idx];
    l_end = {1'b0, lb} + {1'b0, ll};
    c_end = {1'b0, cb} + {1'b0, cl};
    rend  = {1'b0, r_addr} + {1'b0, r_size};
    full  = (cnt >= CntW'(MaxSeg));
  end

  // Update decision, taken in S_EVAL; a second command is held for S_FIX
  logic            join_l, join_r, bad_ovl;
  logic [1:0]      st_eval;
  logic [31:0]     ra_eval;
  logic            retry;
  logic            need_fix;
  rmap_cmd_t       fix_cmd_next;
  logic [IdxW-1:0] fix_sel_next;
  logic [IdxW-1:0] lost_idx;
  logic [32:0]     room;

  always_comb begin
    cmd = '0;
    sel = '0;
    st_eval = ST_DONE;
    ra_eval = '0;
    retry = 1'b0;
    need_fix = 1'b0;
    fix_cmd_next = '0;
    fix_sel_next = '0;
    join_l = has_l_seg && (l_end >= {1'b0, r_addr});
    join_r = has_r_seg && (rend >= {1'b0, rb});
    bad_ovl = (join_l && l_end > {1'b0, r_addr}) || (join_r && rend > {1'b0, rb});
    lost_idx = IdxW'(cnt - CntW'(1));
    if (cnt > CntW'(1) && lens[lost_idx] > lens[IdxW'(cnt - CntW'(2))])
      lost_idx = IdxW'(cnt - CntW'(2));
    room = 33'h0FFFFFFFF - {1'b0, r_addr};
    if (state == S_EVAL) begin
      case (r_mode)
        MODE_INIT: begin
          cmd.op = OP_CLEAR;
          if (r_size != '0 && room != '0) begin
            // Reload cell 0 once the row is empty
            need_fix = 1'b1;
            fix_cmd_next.op = OP_WRITE;
            fix_cmd_next.base = r_addr;
            fix_cmd_next.len = ({1'b0, r_size} > room) ? room[31:0] : r_size;
          end
        end
        MODE_ALLOC: begin
          if (r_size == '0) st_eval = ST_BAD;
          else if (!fit_hit) st_eval = ST_NOFIT;
          else begin
            ra_eval = bases[fit_idx];
            sel = fit_idx;
            if (lens[fit_idx] == r_size) cmd.op = OP_REMOVE;
            else begin
              cmd.op = OP_WRITE;
              cmd.base = bases[fit_idx] + r_size;
              cmd.len = lens[fit_idx] - r_size;
            end
          end
        end
        MODE_FREE: begin
          if (r_addr == '0 || r_size == '0 || rend > 33'h0FFFFFFFF || bad_ovl)
            st_eval = ST_BAD;
          else if (join_l) begin
            sel = li;
            cmd.op = OP_WRITE;
            cmd.base = lb;
            cmd.len = ll + r_size + (join_r ? rl : 32'd0);
            if (join_r) begin
              // Drop the right neighbor, now part of the left one
              need_fix = 1'b1;
              fix_cmd_next.op = OP_REMOVE;
              fix_sel_next = ri;
            end
          end else if (join_r) begin
            sel = ri;
            cmd.op = OP_WRITE;
            cmd.base = r_addr;
            cmd.len = rl + r_size;
          end else if (full) begin
            sel = lost_idx;
            cmd.op = OP_REMOVE;
            retry = 1'b1;
          end else begin
            sel = ri;
            cmd.op = OP_INSERT;
            cmd.base = r_addr;
            cmd.len = r_size;
          end
        end
        MODE_GET: begin
          if (r_size == '0) st_eval = ST_BAD;
          else if (!cov_hit || c_end < rend) st_eval = ST_NOFIT;
          else if (cb == r_addr) begin
            ra_eval = r_addr;
            sel = cov_idx;
            if (cl == r_size) cmd.op = OP_REMOVE;
            else begin
              cmd.op = OP_WRITE;
              cmd.base = cb + r_size;
              cmd.len = cl - r_size;
            end
          end else if (c_end == rend) begin
            ra_eval = r_addr;
            sel = cov_idx;
            cmd.op = OP_WRITE;
            cmd.base = cb;
            cmd.len = cl - r_size;
          end else if (full) st_eval = ST_NOFIT;
          else begin
            // Insert the tail after the cell; trim the head next cycle
            ra_eval = r_addr;
            sel = IdxW'(cov_idx + IdxW'(1));
            cmd.op = OP_INSERT;
            cmd.base = rend[31:0];
            cmd.len = 32'(c_end - rend);
            need_fix = 1'b1;
            fix_cmd_next.op = OP_WRITE;
            fix_cmd_next.base = cb;
            fix_cmd_next.len = r_addr - cb;
            fix_sel_next = cov_idx;
          end
        end
        MODE_AVAIL: ;
        default: st_eval = ST_BAD;
      endcase
    end else if (state == S_FIX) begin
      cmd = fix_cmd;
      sel = fix_sel;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (retry) state_next = S_EVAL;
        else if (r_mode == MODE_AVAIL) state_next = S_SCAN;
        else if (need_fix) state_next = S_FIX;
        else state_next = S_OUT;
      end
      S_FIX: state_next = S_OUT;
      S_SCAN: if (scan == IdxW'(MaxSeg - 1)) state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_mode <= mode;
      r_size <= req_size;
      r_addr <= req_addr;
      lost_valid <= 1'b0;
      lost_base <= '0;
      lost_len <= '0;
      avail_len <= '0;
      scan <= '0;
    end
    if (state == S_EVAL) begin
      status <= st_eval;
      result_addr <= ra_eval;
      fix_cmd <= fix_cmd_next;
      fix_sel <= fix_sel_next;
      if (retry) begin
        lost_valid <= 1'b1;
        lost_base <= bases[lost_idx];
        lost_len <= lens[lost_idx];
      end
    end
    if (state == S_SCAN) begin
      if (flags[scan].valid && lens[scan] > avail_len) avail_len <= lens[scan];
      scan <= scan + IdxW'(1);
    end
  end

endmodule

>>> tb/sv/tb_resource_map_allocator_unit.sv
// ----------------------------------------------------------------------------
// Resource map allocator unit testbench
// Drives directed and random init/alloc/free/get/avail and invalid-mode items through the
// valid/ready channels, predicts each result from a local segment list and
// compares every result field in order.
// ----------------------------------------------------------------------------
module tb_resource_map_allocator_unit
  import rmap_pkg::*;
();

  localparam int NSeg = 16;
  localparam logic [32:0] AddrTop = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] ra;
    logic [31:0] av;
    logic        lv;
    logic [31:0] lb;
    logic [31:0] ll;
  } alloc_res_t;

  typedef struct {
    logic [2:0]  md;
    logic [31:0] sz;
    logic [31:0] ad;
    bit          fixed;
    alloc_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = '0;
  logic [31:0] req_size = '0;
  logic [31:0] req_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_addr;
  logic [31:0] avail_len;
  logic        lost_valid;
  logic [31:0] lost_base;
  logic [31:0] lost_len;

  resource_map_allocator_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the free list
  logic [31:0] fl_base [NSeg];
  logic [31:0] fl_len  [NSeg];
  int unsigned fl_cnt;

  alloc_res_t pending_q [$];
  bit failed = 1'b0;
  bit quiet_out = 1'b0;

  function automatic logic [32:0] fl_end(int k);
    return {1'b0, fl_base[k]} + {1'b0, fl_len[k]};
  endfunction

  function automatic void fl_remove(int k);
    for (int j = k; j + 1 < fl_cnt; j++) begin
      fl_base[j] = fl_base[j+1];
      fl_len[j]  = fl_len[j+1];
    end
    fl_cnt--;
  endfunction

  function automatic void fl_insert(int k, logic [31:0] b, logic [31:0] l);
    for (int j = fl_cnt; j > k; j--) begin
      fl_base[j] = fl_base[j-1];
      fl_len[j]  = fl_len[j-1];
    end
    fl_base[k] = b;
    fl_len[k]  = l;
    fl_cnt++;
  endfunction

  function automatic logic [1:0] fl_free(logic [31:0] sz, logic [31:0] ad,
                                         inout alloc_res_t r);
    logic [32:0] rend;
    int i;
    bit hl, hr;
    int k;
    rend = {1'b0, ad} + {1'b0, sz};
    if (ad == 0 || sz == 0 || rend > AddrTop) return ST_BAD;
    forever begin
      i = 0;
      while (i < fl_cnt && fl_base[i] <= ad) i++;
      hl = (i > 0) && (fl_end(i-1) >= {1'b0, ad});
      hr = (i < fl_cnt) && (rend >= {1'b0, fl_base[i]});
      if ((hl && fl_end(i-1) > {1'b0, ad}) || (hr && rend > {1'b0, fl_base[i]}))
        return ST_BAD;
      if (hl) begin
        fl_len[i-1] += sz;
        if (hr) begin
          fl_len[i-1] += fl_len[i];
          fl_remove(i);
        end
        return ST_DONE;
      end
      if (hr) begin
        fl_base[i] -= sz;
        fl_len[i]  += sz;
        return ST_DONE;
      end
      if (fl_cnt >= NSeg) begin
        k = fl_cnt - 1;
        if (k > 0 && fl_len[k] > fl_len[k-1]) k--;
        r.lv = 1'b1;
        r.lb = fl_base[k];
        r.ll = fl_len[k];
        fl_remove(k);
      end else begin
        fl_insert(i, ad, sz);
        return ST_DONE;
      end
    end
  endfunction

  function automatic logic [1:0] fl_get(logic [31:0] sz, logic [31:0] ad);
    logic [32:0] rend;
    logic [32:0] e;
    int i;
    rend = {1'b0, ad} + {1'b0, sz};
    if (sz == 0) return ST_BAD;
    for (i = 0; i < fl_cnt; i++)
      if (fl_base[i] <= ad && fl_end(i) > {1'b0, ad}) break;
    if (i >= fl_cnt || fl_end(i) < rend) return ST_NOFIT;
    if (fl_base[i] == ad) begin
      if (fl_len[i] == sz) fl_remove(i);
      else begin
        fl_base[i] += sz;
        fl_len[i]  -= sz;
      end
    end else if (fl_end(i) == rend) begin
      fl_len[i] -= sz;
    end else begin
      e = fl_end(i);
      if (fl_cnt >= NSeg) return ST_NOFIT;
      fl_insert(i + 1, rend[31:0], 32'(e - rend));
      fl_len[i] = ad - fl_base[i];
    end
    return ST_DONE;
  endfunction

  function automatic alloc_res_t predict_alloc(logic [2:0] md, logic [31:0] sz,
                                               logic [31:0] ad);
    alloc_res_t r;
    logic [32:0] room;
    logic [1:0] fst;
    r = '0;
    case (md)
      MODE_INIT: begin
        if (sz == 0) fl_cnt = 0;
        else begin
          room = AddrTop - {1'b0, ad};
          fl_base[0] = ad;
          fl_len[0]  = ({1'b0, sz} > room) ? room[31:0] : sz;
          fl_cnt = (fl_len[0] != 0) ? 1 : 0;
        end
      end
      MODE_ALLOC: begin
        if (sz == 0) r.st = ST_BAD;
        else begin
          r.st = ST_NOFIT;
          for (int i = 0; i < fl_cnt; i++) begin
            if (fl_len[i] >= sz) begin
              r.ra = fl_base[i];
              fl_base[i] += sz;
              fl_len[i]  -= sz;
              if (fl_len[i] == 0) fl_remove(i);
              r.st = ST_DONE;
              break;
            end
          end
        end
      end
      MODE_FREE: begin
        fst = fl_free(sz, ad, r);
        r.st = fst;
      end
      MODE_GET: begin
        r.st = fl_get(sz, ad);
        if (r.st == ST_DONE) r.ra = ad;
      end
      MODE_AVAIL: begin
        for (int i = 0; i < fl_cnt; i++)
          if (fl_len[i] > r.av) r.av = fl_len[i];
      end
      default: r.st = ST_BAD;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [2:0] md, logic [31:0] sz, logic [31:0] ad,
                           bit fixed, alloc_res_t fres, bit gaps);
    alloc_res_t p;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    p = predict_alloc(md, sz, ad);
    if (fixed && p != fres) begin
      $display("%0t: table row disagrees with predictor exp=%h act=%h", $time, fres, p);
      failed = 1'b1;
    end
    mode <= md;
    req_size <= sz;
    req_addr <= ad;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(p);
    @(negedge clk);
  endtask

  // output side: random stalls (none in quiet phases), compare at rising edge
  always @(negedge clk) begin
    if (quiet_out || $urandom_range(0, 3) != 0) out_ready <= 1'b1;
    else out_ready <= 1'b0;
  end

  always @(posedge clk) begin
    alloc_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (status !== e.st || result_addr !== e.ra || avail_len !== e.av ||
            lost_valid !== e.lv || lost_base !== e.lb || lost_len !== e.ll) begin
          $display("%0t: mismatch exp st=%0d ra=%h av=%h lv=%0d lb=%h ll=%h", $time,
                   e.st, e.ra, e.av, e.lv, e.lb, e.ll);
          $display("%0t:          act st=%0d ra=%h av=%h lv=%0d lb=%h ll=%h", $time,
                   status, result_addr, avail_len, lost_valid, lost_base, lost_len);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic alloc_res_t mk(logic [1:0] st, logic [31:0] ra, logic [31:0] av);
    alloc_res_t r;
    r = '0;
    r.st = st;
    r.ra = ra;
    r.av = av;
    return r;
  endfunction

  function automatic logic [31:0] rnd_size();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(1, 4));
      default: return 32'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    stim_row_t tbl [$];
    stim_row_t row;
    logic [2:0]  md;
    logic [31:0] sz, ad;
    int n;
    bit gaps;
    alloc_res_t none;
    none = '0;

    tbl.push_back('{MODE_AVAIL, 0, 0, 1'b1, mk(ST_DONE, 0, 0)});
    tbl.push_back('{MODE_ALLOC, 1, 0, 1'b1, mk(ST_NOFIT, 0, 0)});
    tbl.push_back('{MODE_ALLOC, 0, 0, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_FREE, 5, 0, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_FREE, 0, 5, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{3'd5, 0, 0, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_INIT, 32'hFFFF_FFFF, 32'h10, 1'b1, mk(ST_DONE, 0, 0)});
    tbl.push_back('{MODE_AVAIL, 0, 0, 1'b1, mk(ST_DONE, 0, 32'hFFFF_FFEF)});
    tbl.push_back('{MODE_INIT, 0, 32'h10, 1'b1, mk(ST_DONE, 0, 0)});
    tbl.push_back('{MODE_INIT, 100, 0, 1'b1, mk(ST_DONE, 0, 0)});
    tbl.push_back('{MODE_ALLOC, 10, 0, 1'b0, none});
    tbl.push_back('{MODE_GET, 0, 20, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_GET, 5, 20, 1'b0, none});
    tbl.push_back('{MODE_GET, 5, 95, 1'b0, none});
    tbl.push_back('{MODE_GET, 50, 60, 1'b0, none});
    tbl.push_back('{MODE_FREE, 5, 20, 1'b0, none});
    tbl.push_back('{MODE_FREE, 3, 21, 1'b0, none});
    tbl.push_back('{MODE_FREE, 5, 0, 1'b1, mk(ST_BAD, 0, 0)});
    tbl.push_back('{MODE_FREE, 4, 200, 1'b0, none});
    tbl.push_back('{MODE_ALLOC, 32'hFFFF_FFFF, 0, 1'b1, mk(ST_NOFIT, 0, 0)});
    tbl.push_back('{MODE_AVAIL, 0, 0, 1'b0, none});

    for (int i = 0; i < NSeg; i++) begin
      fl_base[i] = '0;
      fl_len[i]  = '0;
    end
    fl_cnt = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (tbl[i]) begin
      row = tbl[i];
      send_item(row.md, row.sz, row.ad, row.fixed, row.res, 1'b1);
    end

    // random phases: each re-inits the map, then mixes scattered frees with alloc/get/avail churn
    for (int ph = 0; ph < 8; ph++) begin
      gaps = (ph < 6);
      quiet_out = (ph >= 6);
      send_item(MODE_INIT, (ph % 2) ? 32'd1000 : $urandom(), 32'($urandom_range(1, 64)),
                1'b0, none, gaps);
      n = 50;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // free a mostly small range; odd phases use a window near the map, even phases any address
            md = MODE_FREE;
            sz = rnd_size();
            ad = (ph % 2) ? 32'($urandom_range(1, 3000)) : $urandom();
            if ($urandom_range(0, 9) == 0) ad = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
          end
          3, 4: begin
            md = MODE_ALLOC;
            sz = rnd_size();
          end
          5, 6: begin
            md = MODE_GET;
            sz = rnd_size();
            if (fl_cnt > 0 && $urandom_range(0, 3) != 0) begin
              int s;
              s = $urandom_range(0, fl_cnt - 1);
              ad = fl_base[s] + 32'($urandom_range(0, 8));
            end else ad = $urandom();
          end
          7: begin
            md = MODE_AVAIL;
            sz = $urandom();
            ad = $urandom();
          end
          8: begin
            md = 3'($urandom_range(5, 7));
            sz = $urandom();
            ad = $urandom();
          end
          default: begin
            md = MODE_FREE;
            sz = $urandom_range(1, 3);
            ad = 32'($urandom_range(1, 2000)) * 8;
          end
        endcase
        if (md != MODE_FREE && md != MODE_GET) ad = $urandom();
        send_item(md, sz, ad, 1'b0, none, gaps);
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
